[sv/sparse_matrix_transpose_defines.svh]
// assertion macros for the sparse matrix transpose block
`ifndef SPARSE_MATRIX_TRANSPOSE_DEFINES_SVH
`define SPARSE_MATRIX_TRANSPOSE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define SMT_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sparse matrix transpose: check failed");
// next-cycle implication, checked out of reset
`define SMT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sparse matrix transpose: check failed");
`else
`define SMT_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define SMT_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

[sv/srt_pkg.sv]
// types and constants shared by the sparse matrix transpose modules
`default_nettype none

package srt_pkg;

    localparam int ROW_W = 8;
    localparam int COL_W = 8;
    localparam int VAL_W = 32;

    // depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // one stored term
    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } srt_entry_t;

    // classified item as it travels through the queue
    typedef struct packed {
        logic                    store;
        logic                    end_mark;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } srt_cmd_t;

    // one result item
    typedef struct packed {
        logic                    out_valid_term;
        logic [ROW_W-1:0]        out_row;
        logic [COL_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    out_last;
        logic                    overflow;
    } srt_result_t;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CNT,
        ST_END,
        ST_PS,
        ST_SC_RD,
        ST_SC_ST,
        ST_SC_WR,
        ST_EM_RD,
        ST_EM_LD,
        ST_EMPTY
    } srt_state_t;

endpackage

`default_nettype wire

[sv/srt_term_if.sv]
// input channel carrying at most one source term per item
`default_nettype none

interface srt_term_if import srt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    has_term;
    logic [ROW_W-1:0]        term_row;
    logic [COL_W-1:0]        term_col;
    logic signed [VAL_W-1:0] term_value;
    logic                    last_term;

    modport source (
        output valid, has_term, term_row, term_col, term_value, last_term,
        input  ready
    );
    modport sink (
        input  valid, has_term, term_row, term_col, term_value, last_term,
        output ready
    );
endinterface

`default_nettype wire

[sv/srt_result_if.sv]
// output channel carrying at most one transposed term per item
`default_nettype none

interface srt_result_if import srt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    out_valid_term;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    out_last;
    logic                    overflow;

    modport source (
        output valid, out_valid_term, out_row, out_col, out_value, out_last, overflow,
        input  ready
    );
    modport sink (
        input  valid, out_valid_term, out_row, out_col, out_value, out_last, overflow,
        output ready
    );
endinterface

`default_nettype wire

[sv/srt_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/srt_front.sv]
// front end: accepts items, classifies them and queues them for the back end
`default_nettype none

module srt_front import srt_pkg::*; #(
    parameter int MAX_DIM = 256
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    srt_term_if.sink    terms,
    input  wire logic   init_busy,
    output logic        q_valid,
    input  wire logic   q_ready,
    output srt_cmd_t    q_cmd
);

    srt_cmd_t           fifo_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               push;
    logic               pop;
    logic               col_ok;
    srt_cmd_t           cmd_in;

    // classification of the incoming item
    always_comb
    begin
        col_ok          = (32'(terms.term_col) < 32'(MAX_DIM));
        cmd_in.store    = terms.has_term & col_ok;
        cmd_in.end_mark = ~terms.has_term | terms.last_term;
        cmd_in.row      = terms.term_row;
        cmd_in.col      = terms.term_col;
        cmd_in.value    = terms.term_value;
    end

    // handshakes on both sides of the queue
    assign terms.ready = (cnt_reg != QCNT_W'(QDEPTH)) && !init_busy;
    assign push        = terms.valid && terms.ready;
    assign q_valid     = (cnt_reg != '0);
    assign pop         = q_valid && q_ready;
    assign q_cmd       = fifo_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

[sv/srt_back.sv]
// back end: counts terms per column, builds column starts, scatters and emits
`default_nettype none

module srt_back import srt_pkg::*; #(
    parameter int MAX_TERMS = 64,
    parameter int MAX_DIM   = 256
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    output logic        q_ready,
    input  wire srt_cmd_t q_cmd,
    output logic        init_busy,
    srt_result_if.source results
);

    localparam int AW     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW     = $clog2(MAX_TERMS + 1);
    localparam int DIM_AW = $clog2(MAX_DIM);
    localparam int EW     = $bits(srt_entry_t);

    srt_state_t         state_reg, state_next;
    logic [DIM_AW-1:0]  idx_reg, idx_next;
    logic [AW-1:0]      tidx_reg, tidx_next;
    logic [CW-1:0]      total_reg, total_next;
    logic [CW-1:0]      sum_reg, sum_next;
    logic               ovf_reg, ovf_next;
    logic               pend_reg, pend_next;
    logic [COL_W-1:0]   col_reg, col_next;
    srt_entry_t         term_reg, term_next;
    logic               ov_reg, ov_next;
    srt_result_t        res_reg, res_next;
    logic               out_free;

    // memory ports
    logic               ts_we;
    logic [AW-1:0]      ts_waddr, ts_raddr;
    srt_entry_t         ts_wdata;
    srt_entry_t         ts_rdata;
    logic               cc_we;
    logic [DIM_AW-1:0]  cc_waddr, cc_raddr;
    logic [CW-1:0]      cc_wdata, cc_rdata;
    logic               cs_we;
    logic [DIM_AW-1:0]  cs_waddr, cs_raddr;
    logic [CW-1:0]      cs_wdata, cs_rdata;
    logic               tr_we;
    logic [AW-1:0]      tr_waddr, tr_raddr;
    srt_entry_t         tr_wdata;
    srt_entry_t         tr_rdata;

    srt_ram #(.WIDTH(EW), .DEPTH(MAX_TERMS)) u_term_store (
        .clk(clk), .we(ts_we), .waddr(ts_waddr), .wdata(ts_wdata),
        .raddr(ts_raddr), .rdata(ts_rdata)
    );

    srt_ram #(.WIDTH(CW), .DEPTH(MAX_DIM)) u_column_count (
        .clk(clk), .we(cc_we), .waddr(cc_waddr), .wdata(cc_wdata),
        .raddr(cc_raddr), .rdata(cc_rdata)
    );

    srt_ram #(.WIDTH(CW), .DEPTH(MAX_DIM)) u_column_start (
        .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .raddr(cs_raddr), .rdata(cs_rdata)
    );

    srt_ram #(.WIDTH(EW), .DEPTH(MAX_TERMS)) u_transposed_store (
        .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
        .raddr(tr_raddr), .rdata(tr_rdata)
    );

    assign q_ready   = (state_reg == ST_IDLE);
    assign init_busy = (state_reg == ST_INIT);
    assign out_free  = !ov_reg || results.ready;

    // sequencer: next state, memory control and output register loading
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        tidx_next  = tidx_reg;
        total_next = total_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        pend_next  = pend_reg;
        col_next   = col_reg;
        term_next  = term_reg;
        ov_next    = ov_reg && !results.ready;
        res_next   = res_reg;

        ts_we    = 1'b0;
        ts_waddr = total_reg[AW-1:0];
        ts_wdata = '{row: q_cmd.row, col: q_cmd.col, value: q_cmd.value};
        ts_raddr = tidx_reg;
        cc_we    = 1'b0;
        cc_waddr = idx_reg;
        cc_wdata = '0;
        cc_raddr = DIM_AW'(q_cmd.col);
        cs_we    = 1'b0;
        cs_waddr = idx_reg;
        cs_wdata = sum_reg;
        cs_raddr = DIM_AW'(term_reg.col);
        tr_we    = 1'b0;
        tr_waddr = AW'(cs_rdata);
        tr_wdata = '{row: term_reg.col, col: term_reg.row, value: term_reg.value};
        tr_raddr = tidx_reg;

        case (state_reg)
            // clearing pass over the column counts after reset
            ST_INIT:
            begin
                cc_we    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == DIM_AW'(MAX_DIM - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            // take one queued item
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.store && (total_reg != CW'(MAX_TERMS)))
                    begin
                        ts_we      = 1'b1;
                        total_next = total_reg + 1'b1;
                        col_next   = q_cmd.col;
                        pend_next  = q_cmd.end_mark;
                        state_next = ST_CNT;
                    end
                    else
                    begin
                        if (q_cmd.store)
                        begin
                            ovf_next = 1'b1;
                        end
                        if (q_cmd.end_mark)
                        begin
                            state_next = ST_END;
                        end
                    end
                end
            end
            // finish the column count increment
            ST_CNT:
            begin
                cc_we      = 1'b1;
                cc_waddr   = DIM_AW'(col_reg);
                cc_wdata   = cc_rdata + 1'b1;
                state_next = pend_reg ? ST_END : ST_IDLE;
            end
            // end of matrix: start the running sum or report an empty one
            ST_END:
            begin
                if (total_reg == '0)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    cc_raddr   = '0;
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = ST_PS;
                end
            end
            // running sum over columns, clearing each count behind it
            ST_PS:
            begin
                cs_we    = 1'b1;
                cc_we    = 1'b1;
                sum_next = sum_reg + cc_rdata;
                cc_raddr = idx_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == DIM_AW'(MAX_DIM - 1))
                begin
                    idx_next   = '0;
                    tidx_next  = '0;
                    state_next = ST_SC_RD;
                end
            end
            // scatter: fetch stored term
            ST_SC_RD:
            begin
                state_next = ST_SC_ST;
            end
            // scatter: fetch the column's next slot
            ST_SC_ST:
            begin
                term_next  = ts_rdata;
                cs_raddr   = DIM_AW'(term_next.col);
                state_next = ST_SC_WR;
            end
            // scatter: place the swapped term and bump the slot
            ST_SC_WR:
            begin
                tr_we    = 1'b1;
                cs_we    = 1'b1;
                cs_waddr = DIM_AW'(term_reg.col);
                cs_wdata = cs_rdata + 1'b1;
                if (CW'(tidx_reg) + CW'(1) == total_reg)
                begin
                    tidx_next  = '0;
                    state_next = ST_EM_RD;
                end
                else
                begin
                    tidx_next  = tidx_reg + 1'b1;
                    state_next = ST_SC_RD;
                end
            end
            // emit: read the next transposed term once the output is free
            ST_EM_RD:
            begin
                if (out_free)
                begin
                    state_next = ST_EM_LD;
                end
            end
            // emit: load the output register
            ST_EM_LD:
            begin
                ov_next                 = 1'b1;
                res_next.out_valid_term = 1'b1;
                res_next.out_row        = tr_rdata.row;
                res_next.out_col        = tr_rdata.col;
                res_next.out_value      = tr_rdata.value;
                res_next.out_last       = (CW'(tidx_reg) + CW'(1) == total_reg);
                res_next.overflow       = ovf_reg;
                if (res_next.out_last)
                begin
                    tidx_next  = '0;
                    total_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    tidx_next  = tidx_reg + 1'b1;
                    state_next = ST_EM_RD;
                end
            end
            // empty matrix gives one marker result
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    res_next   = '{out_valid_term: 1'b0, out_row: '0, out_col: '0,
                                   out_value: '0, out_last: 1'b1, overflow: ovf_reg};
                    total_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            idx_reg   <= '0;
            tidx_reg  <= '0;
            total_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            tidx_reg  <= tidx_next;
            total_reg <= total_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        term_reg <= term_next;
        res_reg  <= res_next;
    end

    // output channel
    assign results.valid          = ov_reg;
    assign results.out_valid_term = res_reg.out_valid_term;
    assign results.out_row        = res_reg.out_row;
    assign results.out_col        = res_reg.out_col;
    assign results.out_value      = res_reg.out_value;
    assign results.out_last       = res_reg.out_last;
    assign results.overflow       = res_reg.overflow;

endmodule

`default_nettype wire

[sv/sparse_matrix_transpose.sv]
// Sparse matrix transpose, coordinate form, counting-sort fast transpose.
// Loading: a stored term reads its column count when taken, then writes it back
// incremented. End of matrix: a running sum over the MAX_DIM columns builds the
// column starts, scatter reads each term, fetches its slot and writes it, and emit
// reads and loads each result. Reset: a clearing pass zeroes the MAX_DIM column
// counts; no item is accepted until it finishes.
`default_nettype none

`include "sparse_matrix_transpose_defines.svh"

module sparse_matrix_transpose import srt_pkg::*; #(
    parameter int MAX_TERMS = 64,
    parameter int MAX_DIM   = 256
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    srt_term_if.sink     terms,
    srt_result_if.source results
);

    logic     q_valid;
    logic     q_ready;
    srt_cmd_t q_cmd;
    logic     init_busy;

    // accept and classify
    srt_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .terms     (terms),
        .init_busy (init_busy),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd)
    );

    // count, sum, scatter and emit
    srt_back #(.MAX_TERMS(MAX_TERMS), .MAX_DIM(MAX_DIM)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .init_busy (init_busy),
        .results   (results)
    );

    // no item enters while the counts are being cleared
    `SMT_ASSERT_SAME(a_init_blocks_input, clk, rst_n, init_busy, !terms.ready)
    // an end of matrix takes the back end out of its taking state
    `SMT_ASSERT_NEXT(a_end_leaves_idle, clk, rst_n, q_valid && q_ready && q_cmd.end_mark, !q_ready)
    // an empty-matrix result is always the last one
    `SMT_ASSERT_SAME(a_empty_is_last, clk, rst_n, results.valid && !results.out_valid_term, results.out_last)

endmodule

`default_nettype wire

[tb/sparse_matrix_transpose_tb.sv]
// testbench for the sparse matrix transpose: coordinate-form terms in, transposed list out
`default_nettype none

module sparse_matrix_transpose_tb;
    import srt_pkg::*;

    localparam int TERM_CAP    = 64;
    localparam int COL_SPAN    = 256;
    localparam int ITEM_TARGET = 280;
    localparam int HOLD_CYCLES = 800;
    localparam int TAIL_CYCLES = 1000;
    localparam int CYCLE_LIMIT = 500000;
    localparam int REPORT_MAX  = 10;

    // one source item as the sender sees it
    typedef struct packed {
        logic                    has_term;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } term_item_t;

    // counting-sort transpose predictor and result checker
    class transpose_scoreboard;
        srt_entry_t  held_terms[$];
        bit          terms_dropped;
        srt_result_t pending_transposed[$];
        int          faults;
        int          results_checked;
        int          matrices;

        // take one accepted item; a matrix end queues its whole transposed list
        function void note_item(term_item_t t);
            srt_entry_t e;
            if (t.has_term)
            begin
                if (held_terms.size() < TERM_CAP)
                begin
                    e.row   = t.row;
                    e.col   = t.col;
                    e.value = t.value;
                    held_terms.push_back(e);
                end
                else
                begin
                    terms_dropped = 1'b1;
                end
                if (!t.last)
                    return;
            end
            transpose_matrix();
        endfunction

        // column counts, running sum of starts, stable scatter, then the list in slot order
        function void transpose_matrix();
            int          col_count[COL_SPAN];
            int          next_slot[COL_SPAN];
            srt_entry_t  slot_term[TERM_CAP];
            srt_result_t r;
            int          total;
            int          sum;
            int          s;
            total = held_terms.size();
            if (total == 0)
            begin
                r = '0;
                r.out_last = 1'b1;
                r.overflow = terms_dropped;
                pending_transposed.push_back(r);
            end
            else
            begin
                foreach (col_count[c])
                    col_count[c] = 0;
                foreach (held_terms[i])
                    col_count[held_terms[i].col]++;
                sum = 0;
                for (int c = 0; c < COL_SPAN; c++)
                begin
                    next_slot[c] = sum;
                    sum += col_count[c];
                end
                foreach (held_terms[i])
                begin
                    s = next_slot[held_terms[i].col];
                    slot_term[s] = held_terms[i];
                    next_slot[held_terms[i].col] = s + 1;
                end
                for (int k = 0; k < total; k++)
                begin
                    r.out_valid_term = 1'b1;
                    r.out_row        = slot_term[k].col;
                    r.out_col        = slot_term[k].row;
                    r.out_value      = slot_term[k].value;
                    r.out_last       = (k == total - 1);
                    r.overflow       = terms_dropped;
                    pending_transposed.push_back(r);
                end
            end
            held_terms.delete();
            terms_dropped = 1'b0;
            matrices++;
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(srt_result_t got);
            srt_result_t want;
            bit          bad;
            results_checked++;
            if (pending_transposed.size() == 0)
            begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("unexpected result: vt=%0b r=%0d c=%0d v=%0d l=%0b o=%0b",
                             got.out_valid_term, got.out_row, got.out_col, got.out_value,
                             got.out_last, got.overflow);
                return;
            end
            want = pending_transposed.pop_front();
            bad = (got.out_valid_term !== want.out_valid_term)
               || (got.out_row !== want.out_row)
               || (got.out_col !== want.out_col)
               || (got.out_value !== want.out_value)
               || (got.out_last !== want.out_last)
               || (got.overflow !== want.overflow);
            if (bad)
            begin
                faults++;
                if (faults <= REPORT_MAX)
                begin
                    $display("mismatch: expected vt=%0b r=%0d c=%0d v=%0d l=%0b o=%0b",
                             want.out_valid_term, want.out_row, want.out_col,
                             want.out_value, want.out_last, want.overflow);
                    $display("          actual   vt=%0b r=%0d c=%0d v=%0d l=%0b o=%0b",
                             got.out_valid_term, got.out_row, got.out_col,
                             got.out_value, got.out_last, got.overflow);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    srt_term_if   term_bus ();
    srt_result_if result_bus ();

    transpose_scoreboard sb = new();

    int items_sent  = 0;
    int hold_orders = 0;
    int cycles      = 0;
    int burst_left  = 4;
    bit no_gaps     = 1'b0;

    sparse_matrix_transpose #(
        .MAX_TERMS (TERM_CAP),
        .MAX_DIM   (COL_SPAN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .terms   (term_bus),
        .results (result_bus)
    );

    // clock
    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (result_bus.valid && result_bus.ready)
            sb.check_result({result_bus.out_valid_term, result_bus.out_row, result_bus.out_col,
                             result_bus.out_value, result_bus.out_last, result_bus.overflow});
    end

    // receiver ready: random stretches of patterns, plus long hold-offs on request
    initial
    begin : ready_driver
        int       mode;
        int       stretch;
        int       hold_left;
        int       holds_seen;
        bit [7:0] mask;
        mode       = 0;
        stretch    = 0;
        hold_left  = 0;
        holds_seen = 0;
        mask       = 8'hff;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_orders)
            begin
                holds_seen = hold_orders;
                hold_left  = HOLD_CYCLES;
            end
            if (stretch == 0)
            begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(20, 120);
                mask    = 8'($urandom) | 8'h01;
            end
            stretch--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: result_bus.ready <= 1'b1;
                    1: result_bus.ready <= 1'($urandom_range(0, 1));
                    2: result_bus.ready <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        result_bus.ready <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                endcase
            end
        end
    end

    function automatic term_item_t mk(bit has, int row, int col, logic [31:0] value, bit last);
        term_item_t t;
        t.has_term = has;
        t.row      = ROW_W'(row);
        t.col      = COL_W'(col);
        t.value    = value;
        t.last     = last;
        return t;
    endfunction

    // random term, columns bunched at times so that columns collide
    function automatic term_item_t random_term(bit last);
        term_item_t t;
        t.has_term = 1'b1;
        t.row      = ROW_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: t.col = COL_W'($urandom_range(0, 7));
            1: t.col = COL_W'(255 - $urandom_range(0, 3));
            default: t.col = COL_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
            0: t.value = 32'h8000_0000;
            1: t.value = 32'h7fff_ffff;
            2: t.value = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
            default: t.value = $urandom;
        endcase
        t.last = last;
        return t;
    endfunction

    // offer one item until accepted, then keep the burst or open a gap
    task automatic offer(input term_item_t t);
        term_bus.valid      <= 1'b1;
        term_bus.has_term   <= t.has_term;
        term_bus.term_row   <= t.row;
        term_bus.term_col   <= t.col;
        term_bus.term_value <= t.value;
        term_bus.last_term  <= t.last;
        @(posedge clk);
        while (!term_bus.ready)
            @(posedge clk);
        sb.note_item(t);
        items_sent++;
        if (!no_gaps)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                term_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // one matrix: ending 0 marks the final term last, 1 and 2 close with a bare end item
    task automatic send_matrix(input int n_terms, input int ending);
        term_item_t t;
        for (int k = 0; k < n_terms; k++)
            offer(random_term(ending == 0 && k == n_terms - 1));
        if (ending != 0 || n_terms == 0)
        begin
            t = random_term(ending == 1);
            t.has_term = 1'b0;
            offer(t);
        end
    endtask

    // sender pauses until every expected result has come
    task automatic drain();
        term_bus.valid <= 1'b0;
        while (sb.pending_transposed.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int n;
        rst_n               <= 1'b0;
        term_bus.valid      <= 1'b0;
        term_bus.has_term   <= 1'b0;
        term_bus.term_row   <= '0;
        term_bus.term_col   <= '0;
        term_bus.term_value <= '0;
        term_bus.last_term  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // lone end items give empty matrices
        offer(mk(0, 8'ha5, 8'h5a, 32'hdead_beef, 0));
        offer(mk(0, 255, 255, 32'hffff_ffff, 1));
        // single term at the field extremes
        offer(mk(1, 255, 0, 32'h7fff_ffff, 1));
        // several terms in the top column keep arrival order
        offer(mk(1, 0, 255, 32'h8000_0000, 0));
        offer(mk(1, 255, 255, 32'hffff_ffff, 0));
        offer(mk(1, 0, 0, 32'h0, 0));
        offer(mk(1, 128, 255, 32'h1, 0));
        offer(mk(1, 255, 0, 32'h7fff_ffff, 1));
        // bare end item without last closes a filled matrix
        offer(mk(1, 3, 7, 32'h1234_5678, 0));
        offer(mk(1, 9, 2, -5, 0));
        offer(mk(1, 3, 2, 55, 0));
        offer(mk(0, 8'h3c, 8'hc3, 32'h5555_aaaa, 0));
        // bare end item with last closes a filled matrix
        offer(mk(1, 1, 1, 32'haaaa_aaaa, 0));
        offer(mk(1, 254, 1, 32'h5555_5555, 0));
        offer(mk(0, 8'h12, 8'h34, 32'h0f0f_0f0f, 1));
        // same position repeated
        offer(mk(1, 4, 4, 1, 0));
        offer(mk(1, 4, 4, 2, 0));
        offer(mk(1, 4, 4, 3, 1));
        // back-to-back empty matrices
        offer(mk(0, 0, 0, 0, 0));
        offer(mk(0, 255, 255, 32'hffff_ffff, 0));
        drain();

        // long receiver hold while a full store and small matrices keep coming
        no_gaps = 1'b1;
        hold_orders <= hold_orders + 1;
        send_matrix(TERM_CAP, 0);
        send_matrix(3, 0);
        send_matrix(2, 2);
        no_gaps = 1'b0;
        drain();

        // store full: the extra terms are dropped and flag overflow
        send_matrix(TERM_CAP + 3, 0);
        send_matrix(TERM_CAP + 1, 1);
        drain();

        // random matrices, mostly small
        while (items_sent < ITEM_TARGET)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 19))
                0:       n = 0;
                1, 2, 3: n = $urandom_range(9, 30);
                default: n = $urandom_range(1, 8);
            endcase
            send_matrix(n, ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2));
            if ($urandom_range(0, 9) == 0)
                drain();
        end
        no_gaps = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d items in %0d matrices, %0d transposed results checked",
                 items_sent, sb.matrices, sb.results_checked);
        $display("tb: covered empty, full, overflowed and column-colliding matrices under stalls");
        if (sb.faults == 0 && sb.pending_transposed.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
